// ===== rtl/core/bhfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bhfr_pkg
// types and codes shared by the byte histogram ranking unit
// ----------------------------------------------------------------------------
`default_nettype none

package bhfr_pkg;

    localparam int SYM_BITS  = 8;
    localparam int SYM_NUM   = 256;
    localparam int DIST_BITS = 9;
    localparam int FREQ_BITS = 32;

    localparam logic [1:0] FUNC_COUNT = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]          func;
        logic [SYM_BITS-1:0] data_byte;
        logic [SYM_BITS-1:0] rank;
    } t_in_beat;

    typedef struct packed {
        logic [SYM_BITS-1:0]  symbol;
        logic [FREQ_BITS-1:0] frequency;
        logic                 present;
        logic [DIST_BITS-1:0] distinct_count;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== rtl/core/bhfr_count_mem.sv =====
// ----------------------------------------------------------------------------
// bhfr_count_mem
// 256-entry count store, one write and one registered read per cycle,
// per-entry valid bits give the cleared value without a sweep
// ----------------------------------------------------------------------------
`default_nettype none

module bhfr_count_mem
    import bhfr_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_clr,
    input  wire logic                  i_rd_en,
    input  wire logic [SYM_BITS-1:0]   i_rd_addr,
    output logic      [COUNT_BITS-1:0] o_rd_data,
    input  wire logic                  i_wr_en,
    input  wire logic [SYM_BITS-1:0]   i_wr_addr,
    input  wire logic [COUNT_BITS-1:0] i_wr_data
);

    logic [COUNT_BITS-1:0] r_mem [SYM_NUM];
    logic [SYM_NUM-1:0]    r_vld;
    logic [COUNT_BITS-1:0] r_rd_raw;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_raw <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // invalid entry reads as zero
    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;

endmodule

`default_nettype wire

// ===== rtl/core/bhfr_rank_mem.sv =====
// ----------------------------------------------------------------------------
// bhfr_rank_mem
// 256 x 8 store of byte values in rank order, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bhfr_rank_mem
    import bhfr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rd_en,
    input  wire logic [SYM_BITS-1:0] i_rd_addr,
    output logic      [SYM_BITS-1:0] o_rd_data,
    input  wire logic                i_wr_en,
    input  wire logic [SYM_BITS-1:0] i_wr_addr,
    input  wire logic [SYM_BITS-1:0] i_wr_data
);

    logic [SYM_BITS-1:0] r_mem [SYM_NUM];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/byte_histogram_frequency_rank_unit.sv =====
// ----------------------------------------------------------------------------
// byte_histogram_frequency_rank_unit
// byte histogram with ranking by ascending count, ties by byte value
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                      | beat
//  ---------+-----------+--------------------------------+-----------
//  in       | input     | i_in_valid / o_in_stall        | t_in_beat
//  out      | output    | o_out_valid / i_out_stall      | t_out_beat
//
//  count beat: count store read, then saturating write back
//  clear beat: valid bits of the count store drop at once
//  read beat: rank store read, count store read, then output load when the ranking is current;
//  after a count or clear the first read rebuilds the ranking first,
//  sweeping the count store through its single read port once per
//  present byte
//  reset is synchronous; no clearing pass is needed
//  a held result stalls only the next read beat, not counts or clears
// ----------------------------------------------------------------------------
`default_nettype none

module byte_histogram_frequency_rank_unit
    import bhfr_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT_WR,
        S_B_LDV,
        S_B_GETV,
        S_B_SWEEP,
        S_B_WR,
        S_RD_SYM,
        S_RD_CNT,
        S_RD_OUT
    } t_state;

    t_state                r_state;
    logic [SYM_BITS-1:0]   r_byte;     // counted byte
    logic [SYM_BITS-1:0]   r_rank;     // asked rank
    logic                  r_rank_ok;  // ranking matches counts
    logic [DIST_BITS-1:0]  r_dist;     // distinct bytes in ranking
    logic [SYM_BITS-1:0]   r_v;        // byte being placed
    logic [COUNT_BITS-1:0] r_c;        // its count
    logic [SYM_BITS-1:0]   r_u;        // sweep issue address
    logic                  r_last;     // all sweep reads issued
    logic                  r_pend;     // sweep read data arrives
    logic [SYM_BITS-1:0]   r_pu;       // address of arriving data
    logic [SYM_BITS-1:0]   r_pos;      // rank of r_v
    logic [SYM_BITS-1:0]   r_sym;

    // count store ports
    logic                  w_c_clr;
    logic                  w_c_rd_en;
    logic [SYM_BITS-1:0]   w_c_rd_addr;
    logic [COUNT_BITS-1:0] w_c_rd_data;
    logic                  w_c_wr_en;
    logic [COUNT_BITS-1:0] w_c_wr_data;
    // rank store ports
    logic                  w_r_rd_en;
    logic [SYM_BITS-1:0]   w_r_rd_data;
    logic                  w_r_wr_en;

    logic                  w_accept;
    logic                  w_before;   // arriving entry ranks ahead of r_v
    logic [63:0]           w_wide;
    logic                  w_present;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    bhfr_count_mem #(
        .COUNT_BITS(COUNT_BITS)
    ) u_count (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (w_c_clr),
        .i_rd_en  (w_c_rd_en),
        .i_rd_addr(w_c_rd_addr),
        .o_rd_data(w_c_rd_data),
        .i_wr_en  (w_c_wr_en),
        .i_wr_addr(r_byte),
        .i_wr_data(w_c_wr_data)
    );

    bhfr_rank_mem u_rank (
        .i_clk    (i_clk),
        .i_rd_en  (w_r_rd_en),
        .i_rd_addr(r_rank),
        .o_rd_data(w_r_rd_data),
        .i_wr_en  (w_r_wr_en),
        .i_wr_addr(r_pos),
        .i_wr_data(r_v)
    );

    // memory control
    always_comb begin
        w_c_clr     = w_accept && (i_in_data.func == FUNC_CLEAR);
        w_c_rd_en   = 1'b0;
        w_c_rd_addr = r_v;
        unique case (r_state)
            S_IDLE: begin
                w_c_rd_en   = w_accept && (i_in_data.func == FUNC_COUNT);
                w_c_rd_addr = i_in_data.data_byte;
            end
            S_B_LDV: begin
                w_c_rd_en = 1'b1;
            end
            S_B_SWEEP: begin
                w_c_rd_en   = !r_last;
                w_c_rd_addr = r_u;
            end
            S_RD_CNT: begin
                w_c_rd_en   = 1'b1;
                w_c_rd_addr = w_r_rd_data;
            end
            default: begin
                w_c_rd_en = 1'b0;
            end
        endcase
        // saturating increment
        w_c_wr_en   = (r_state == S_CNT_WR);
        w_c_wr_data = (&w_c_rd_data) ? w_c_rd_data : w_c_rd_data + 1'b1;
        w_r_rd_en   = (r_state == S_RD_SYM);
        w_r_wr_en   = (r_state == S_B_WR);
    end

    // stable order: smaller count first, then smaller byte value
    assign w_before = (w_c_rd_data != '0) &&
                      ((w_c_rd_data < r_c) || ((w_c_rd_data == r_c) && (r_pu < r_v)));

    assign w_wide    = 64'(w_c_rd_data);
    assign w_present = ({1'b0, r_rank} < r_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rank_ok   <= 1'b0;
            r_dist      <= '0;
            o_out_valid <= 1'b0;
            r_last      <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            // output stage reloads itself in S_RD_OUT
            if (o_out_valid && !i_out_stall && (r_state != S_RD_OUT)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_byte <= i_in_data.data_byte;
                    r_rank <= i_in_data.rank;
                    if (w_accept) begin
                        priority case (i_in_data.func)
                            FUNC_COUNT: begin
                                r_rank_ok <= 1'b0;
                                r_state   <= S_CNT_WR;
                            end
                            FUNC_CLEAR: begin
                                r_rank_ok <= 1'b0;
                            end
                            FUNC_READ: begin
                                if (r_rank_ok) begin
                                    r_state <= S_RD_SYM;
                                end else begin
                                    r_v     <= '0;
                                    r_dist  <= '0;
                                    r_state <= S_B_LDV;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CNT_WR: begin
                    r_state <= S_IDLE;
                end
                S_B_LDV: begin
                    r_state <= S_B_GETV;
                end
                S_B_GETV: begin
                    r_c    <= w_c_rd_data;
                    r_u    <= '0;
                    r_pos  <= '0;
                    r_last <= 1'b0;
                    r_pend <= 1'b0;
                    if (w_c_rd_data != '0) begin
                        r_state <= S_B_SWEEP;
                    end else if (&r_v) begin
                        r_rank_ok <= 1'b1;
                        r_state   <= S_RD_SYM;
                    end else begin
                        r_v     <= r_v + 1'b1;
                        r_state <= S_B_LDV;
                    end
                end
                S_B_SWEEP: begin
                    if (!r_last) begin
                        r_pu   <= r_u;
                        r_pend <= 1'b1;
                        r_u    <= r_u + 1'b1;
                        r_last <= &r_u;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        if (w_before) begin
                            r_pos <= r_pos + 1'b1;
                        end
                        if (&r_pu) begin
                            r_state <= S_B_WR;
                        end
                    end
                end
                S_B_WR: begin
                    r_dist <= r_dist + 1'b1;
                    if (&r_v) begin
                        r_rank_ok <= 1'b1;
                        r_state   <= S_RD_SYM;
                    end else begin
                        r_v     <= r_v + 1'b1;
                        r_state <= S_B_LDV;
                    end
                end
                S_RD_SYM: begin
                    r_state <= S_RD_CNT;
                end
                S_RD_CNT: begin
                    r_sym   <= w_r_rd_data;
                    r_state <= S_RD_OUT;
                end
                S_RD_OUT: begin
                    // wait for the output register to free up
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid               <= 1'b1;
                        o_out_data.present        <= w_present;
                        o_out_data.distinct_count <= r_dist;
                        o_out_data.symbol         <= w_present ? r_sym : '0;
                        if (!w_present) begin
                            o_out_data.frequency <= '0;
                        end else if (|w_wide[63:32]) begin
                            o_out_data.frequency <= '1;
                        end else begin
                            o_out_data.frequency <= w_wide[31:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bhfr_checker.sv =====
// ----------------------------------------------------------------------------
// bhfr_checker
// port-level checks for the byte histogram ranking unit
// ----------------------------------------------------------------------------
`default_nettype none

module bhfr_checker
    import bhfr_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_beat o_out_data
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    // missing rank gives an empty entry
    a_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.present |->
            o_out_data.symbol == '0 && o_out_data.frequency == '0)
        else $error("absent entry not zeroed");

    // a present entry has a nonzero count and a nonzero distinct total
    a_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.present |->
            o_out_data.frequency != '0 && o_out_data.distinct_count != '0)
        else $error("present entry inconsistent");

endmodule

bind byte_histogram_frequency_rank_unit bhfr_checker u_bhfr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);

`default_nettype wire
